// ----- rtl/core/mat_pkg.sv -----
package mat_pkg;

   // Default build parameters
   localparam int AXES_DEF       = 6;
   localparam int COUNT_BITS_DEF = 12;
   localparam int TURN_BITS_DEF  = 16;

   // Fixed field widths
   localparam int MASK_W    = 6;
   localparam int GAIN_W    = 20;
   localparam int AXIS_W    = 3;
   localparam int RAW_W     = 12;
   localparam int TURNS_W   = 16;
   localparam int UNW_W     = 28;
   localparam int POS_W     = 32;
   localparam int CSR_DATA_W = GAIN_W;

   // Register reset values
   localparam logic [MASK_W-1:0] MASK_RESET = '0;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 20'd65615;

   // Register indexes
   typedef enum logic {
      CSR_CONNECTED_MASK,
      CSR_POSITION_GAIN
   } csr_index_type;

   // Request commands
   typedef enum logic {
      CMD_CAPTURE,
      CMD_SAMPLE
   } cmd_type;

   // Quadrant codes; none means no sample seen yet
   typedef enum logic [2:0] {
      QUAD_NONE,
      QUAD_1,
      QUAD_2,
      QUAD_3,
      QUAD_4
   } quad_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [AXIS_W-1:0] axis;
      logic [RAW_W-1:0]  raw_angle;
   } req_type;

   typedef struct packed {
      logic [AXIS_W-1:0]        axis_out;
      logic signed [TURNS_W-1:0] turns;
      logic signed [UNW_W-1:0]   unwrapped_count;
      logic signed [POS_W-1:0]   scaled_position;
   } rsp_type;

   // Tracker result toward the scaling stages
   typedef struct packed {
      logic                      emit;
      logic [AXIS_W-1:0]         axis;
      logic signed [TURNS_W-1:0] turns;
      logic signed [UNW_W-1:0]   unw;
   } trk_out_type;

endpackage

// ----- rtl/core/mat_chan_if.sv -----
interface mat_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/mat_track.sv -----
module mat_track #(
   parameter int AXES       = mat_pkg::AXES_DEF,
   parameter int COUNT_BITS = mat_pkg::COUNT_BITS_DEF,
   parameter int TURN_BITS  = mat_pkg::TURN_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        update,
   input  logic [mat_pkg::MASK_W-1:0]  connected_mask,
   input  mat_pkg::req_type            item,
   output mat_pkg::trk_out_type        result
);
   import mat_pkg::*;

   localparam int SEL_W     = (AXES > 1) ? $clog2(AXES) : 1;
   localparam int QUARTER_I = 1 << (COUNT_BITS - 2);
   localparam logic [COUNT_BITS:0] Q1 = (COUNT_BITS + 1)'(QUARTER_I);
   localparam logic [COUNT_BITS:0] Q2 = (COUNT_BITS + 1)'(2 * QUARTER_I);
   localparam logic [COUNT_BITS:0] Q3 = (COUNT_BITS + 1)'(3 * QUARTER_I);
   localparam logic signed [TURN_BITS-1:0] TURN_MAX = {1'b0, {(TURN_BITS - 1){1'b1}}};
   localparam logic signed [TURN_BITS-1:0] TURN_MIN = {1'b1, {(TURN_BITS - 1){1'b0}}};
   localparam logic signed [47:0] UNW_MAX48 = 48'sd134217727;
   localparam logic signed [47:0] UNW_MIN48 = -48'sd134217728;

   // Per-axis state
   logic [COUNT_BITS-1:0]       zero_ff [AXES];
   quad_type                    quad_ff [AXES];
   logic signed [TURN_BITS-1:0] turn_ff [AXES];

   logic [SEL_W-1:0]            idx;
   logic [7:0]                  mask_ext;
   logic                        axis_ok;
   logic [15:0]                 raw16;
   logic [COUNT_BITS-1:0]       raw_c;
   logic [COUNT_BITS-1:0]       corr;
   quad_type                    quad_new;
   quad_type                    quad_last;
   logic signed [TURN_BITS-1:0] turn_cur;
   logic signed [TURN_BITS-1:0] turn_new;
   logic signed [31:0]          turn32;
   logic signed [TURN_BITS+COUNT_BITS-1:0] unw_full;
   logic signed [47:0]          unw48;

   // Axis select and presence
   assign idx      = item.axis[SEL_W-1:0];
   assign mask_ext = 8'(connected_mask);
   assign axis_ok  = ({1'b0, item.axis} < 4'(AXES)) && mask_ext[item.axis];

   // Offset correction, quadrant and turn update
   always_comb begin
      raw16     = 16'(item.raw_angle);
      raw_c     = raw16[COUNT_BITS-1:0];
      corr      = raw_c - zero_ff[idx];
      quad_last = quad_ff[idx];
      turn_cur  = turn_ff[idx];
      if ({1'b0, corr} <= Q1) begin
         quad_new = QUAD_1;
      end else if ({1'b0, corr} <= Q2) begin
         quad_new = QUAD_2;
      end else if ({1'b0, corr} <= Q3) begin
         quad_new = QUAD_3;
      end else begin
         quad_new = QUAD_4;
      end
      turn_new = turn_cur;
      if (quad_new == QUAD_1 && quad_last == QUAD_4 && turn_cur != TURN_MAX) begin
         turn_new = turn_cur + 2'sd1;
      end
      if (quad_new == QUAD_4 && quad_last == QUAD_1 && turn_cur != TURN_MIN) begin
         turn_new = turn_cur - 2'sd1;
      end
   end

   // Unwrapped count, saturated to the output range
   always_comb begin
      turn32   = 32'(turn_new);
      unw_full = $signed({turn_new, corr});
      unw48    = 48'(unw_full);
      result.emit  = axis_ok && (item.cmd == CMD_SAMPLE);
      result.axis  = item.axis;
      result.turns = turn32[TURNS_W-1:0];
      if (unw48 > UNW_MAX48) begin
         result.unw = UNW_MAX48[UNW_W-1:0];
      end else if (unw48 < UNW_MIN48) begin
         result.unw = UNW_MIN48[UNW_W-1:0];
      end else begin
         result.unw = unw48[UNW_W-1:0];
      end
   end

   // State write on each request leaving the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AXES; i++) begin
            zero_ff[i] <= '0;
            quad_ff[i] <= QUAD_NONE;
            turn_ff[i] <= '0;
         end
      end else if (update && axis_ok) begin
         if (item.cmd == CMD_CAPTURE) begin
            zero_ff[idx] <= raw_c;
         end else begin
            quad_ff[idx] <= quad_new;
            turn_ff[idx] <= turn_new;
         end
      end
   end

   // A sample never moves the turn count by more than one
   assert property (@(posedge clock) disable iff (reset)
      update && axis_ok && item.cmd == CMD_SAMPLE
      |-> (turn_new == turn_cur) || (turn_new == turn_cur + 2'sd1)
          || (turn_new == turn_cur - 2'sd1))
      else $error("turn count stepped by more than one");

   // A capture leaves quadrant and turn state alone
   assert property (@(posedge clock) disable iff (reset)
      update && axis_ok && item.cmd == CMD_CAPTURE
      |=> quad_ff[$past(idx)] == $past(quad_last)
          && turn_ff[$past(idx)] == $past(turn_cur))
      else $error("capture changed tracking state");

   // Any sample leaves a real quadrant behind
   assert property (@(posedge clock) disable iff (reset)
      update && axis_ok && item.cmd == CMD_SAMPLE
      |=> quad_ff[$past(idx)] != QUAD_NONE)
      else $error("sample left no quadrant");

endmodule

// ----- rtl/core/multi_turn_angle_tracker.sv -----
// Multi-turn angle tracker for up to AXES absolute encoders. A capture
// request stores the raw count as that axis's zero and returns nothing; a
// sample request returns the axis, the saturated turn count, the unwrapped
// count (turns * 2^COUNT_BITS plus the offset-corrected count) and the
// position floor(unwrapped * position_gain / 2^16), saturated to 32 bits.
// Requests for axes that are absent or not set in connected_mask are
// dropped. One request is taken per clock unless every stage is full and
// rsp.ready is low; a result is offered once its request has passed the
// input register, the per-axis state update register, the registered gain
// multiply and the result register. Write the registers only while no
// request is in flight.
module multi_turn_angle_tracker #(
   parameter int AXES       = mat_pkg::AXES_DEF,
   parameter int COUNT_BITS = mat_pkg::COUNT_BITS_DEF,
   parameter int TURN_BITS  = mat_pkg::TURN_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   mat_chan_if.sink                      req,
   mat_chan_if.source                    rsp,
   input  logic                          csr_we,
   input  mat_pkg::csr_index_type        csr_index,
   input  logic [mat_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import mat_pkg::*;

   localparam int PROD_W = UNW_W + GAIN_W + 1;
   localparam logic signed [PROD_W-17:0] POS_MAX = (PROD_W - 16)'(64'sd2147483647);
   localparam logic signed [PROD_W-17:0] POS_MIN = (PROD_W - 16)'(-64'sd2147483648);

   // Configuration registers
   logic [MASK_W-1:0] mask_ff;
   logic [GAIN_W-1:0] gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= MASK_RESET;
         gain_ff <= GAIN_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CONNECTED_MASK: mask_ff <= csr_wdata[MASK_W-1:0];
            CSR_POSITION_GAIN:  gain_ff <= csr_wdata[GAIN_W-1:0];
         endcase
      end
   end

   // Pipeline registers
   logic                      s1_v_ff;
   req_type                   s1_ff;
   logic                      s2_v_ff;
   trk_out_type               s2_ff;
   logic                      s3_v_ff;
   logic [AXIS_W-1:0]         s3_axis_ff;
   logic signed [TURNS_W-1:0] s3_turns_ff;
   logic signed [UNW_W-1:0]   s3_unw_ff;
   logic signed [PROD_W-1:0]  s3_prod_ff;
   logic                      out_v_ff;
   rsp_type                   out_ff;

   logic                      out_ready;
   logic                      s3_ready;
   logic                      s2_ready;
   logic                      s1_ready;
   logic                      s1_adv;
   trk_out_type               trk;
   logic signed [PROD_W-1:0]  prod_in;
   logic signed [PROD_W-17:0] pos_sh;
   logic signed [POS_W-1:0]   pos_in;

   // Stall chain: each stage moves when the next is empty or moving
   assign out_ready = !out_v_ff || rsp.ready;
   assign s3_ready  = !s3_v_ff || out_ready;
   assign s2_ready  = !s2_v_ff || s3_ready;
   assign s1_ready  = !s1_v_ff || s2_ready;
   assign s1_adv    = s1_v_ff && s2_ready;
   assign req.ready = s1_ready;

   // Per-axis offset, quadrant and turn tracking
   mat_track #(
      .AXES       (AXES),
      .COUNT_BITS (COUNT_BITS),
      .TURN_BITS  (TURN_BITS)
   ) u_track (
      .clock          (clock),
      .reset          (reset),
      .update         (s1_adv),
      .connected_mask (mask_ff),
      .item           (s1_ff),
      .result         (trk)
   );

   // Gain multiply and Q16 shift with saturation
   assign prod_in = $signed(s2_ff.unw) * $signed({1'b0, gain_ff});
   assign pos_sh  = s3_prod_ff[PROD_W-1:16];

   always_comb begin
      if (pos_sh > POS_MAX) begin
         pos_in = POS_MAX[POS_W-1:0];
      end else if (pos_sh < POS_MIN) begin
         pos_in = POS_MIN[POS_W-1:0];
      end else begin
         pos_in = pos_sh[POS_W-1:0];
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_v_ff <= req.valid;
         if (s2_ready) s2_v_ff <= s1_adv && trk.emit;
         if (s3_ready) s3_v_ff <= s2_v_ff;
         if (out_ready) out_v_ff <= s3_v_ff;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (s1_ready) s1_ff <= req.payload;
      if (s2_ready) s2_ff <= trk;
      if (s3_ready) begin
         s3_axis_ff  <= s2_ff.axis;
         s3_turns_ff <= s2_ff.turns;
         s3_unw_ff   <= s2_ff.unw;
         s3_prod_ff  <= prod_in;
      end
      if (out_ready) begin
         out_ff.axis_out        <= s3_axis_ff;
         out_ff.turns           <= s3_turns_ff;
         out_ff.unwrapped_count <= s3_unw_ff;
         out_ff.scaled_position <= pos_in;
      end
   end

   assign rsp.valid   = out_v_ff;
   assign rsp.payload = out_ff;

   // Captures and dropped axes never reach the scaling stages
   assert property (@(posedge clock) disable iff (reset)
      s1_adv && s1_ff.cmd == CMD_CAPTURE |=> !s2_v_ff)
      else $error("capture request produced a result");

   // Request side stalls only with every stage full
   assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> s1_v_ff && s2_v_ff && s3_v_ff && out_v_ff)
      else $error("request stalled with a free stage");

   // Reported axis is always one that exists
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> {1'b0, rsp.payload.axis_out} < 4'(AXES))
      else $error("result for a nonexistent axis");

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
   import mat_pkg::*;

   localparam int AXES        = AXES_DEF;
   localparam int QUARTER     = 1 << (COUNT_BITS_DEF - 2);
   localparam int TURN_MAX    = 32767;
   localparam int TURN_MIN    = -32768;
   localparam int SETTLE      = 8;
   localparam int SWEEP_TURNS = 20;

   logic                  clock;
   logic                  reset;
   logic                  csr_we = 1'b0;
   csr_index_type         csr_index = CSR_CONNECTED_MASK;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   mat_chan_if #(.payload_type(req_type)) req_chan ();
   mat_chan_if #(.payload_type(rsp_type)) rsp_chan ();

   multi_turn_angle_tracker DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .rsp       (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Tracker model state and its copy of the registers
   logic [MASK_W-1:0] mask_cfg;
   logic [GAIN_W-1:0] gain_cfg;
   logic [RAW_W-1:0]  zero_offset [AXES];
   quad_type          last_quad [AXES];
   int                turn_count [AXES];

   req_type request_queue [$];
   rsp_type awaited_reports [$];

   int  tx_idle_pct = 0;
   int  rx_stall_pct = 0;
   logic rx_hold = 1'b0;
   int  sent_count = 0;
   int  checked_count = 0;
   int  fault_count = 0;
   logic [RAW_W-1:0] walk_pos [8];

   rsp_type predicted_report;
   rsp_type want_report;

   // Clock and known levels on every channel input
   initial begin
      clock = 1'b0;
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #40000000;
      $display("multi_turn_angle_tracker test failed");
      $finish;
   end

   function automatic quad_type quadrant_of(input logic [RAW_W-1:0] count);
      if (count <= QUARTER) return QUAD_1;
      if (count <= 2 * QUARTER) return QUAD_2;
      if (count <= 3 * QUARTER) return QUAD_3;
      return QUAD_4;
   endfunction

   // Apply one request to the model; returns 1 when a position report results
   function automatic bit track_request(input req_type r, output rsp_type rep);
      int               ax;
      logic [RAW_W-1:0] corr;
      quad_type         q;
      longint           unw;
      longint           pos;
      ax = int'(r.axis);
      rep = '0;
      if (ax >= AXES || !mask_cfg[ax]) return 0;
      if (r.cmd == CMD_CAPTURE) begin
         zero_offset[ax] = r.raw_angle;
         return 0;
      end
      corr = r.raw_angle - zero_offset[ax];
      q = quadrant_of(corr);
      if (q != last_quad[ax]) begin
         if (q == QUAD_1 && last_quad[ax] == QUAD_4 && turn_count[ax] < TURN_MAX)
            turn_count[ax]++;
         if (q == QUAD_4 && last_quad[ax] == QUAD_1 && turn_count[ax] > TURN_MIN)
            turn_count[ax]--;
         last_quad[ax] = q;
      end
      unw = longint'(turn_count[ax]) * (longint'(1) << COUNT_BITS_DEF) + longint'(corr);
      if (unw > 134217727) unw = 134217727;
      if (unw < -134217728) unw = -134217728;
      // arithmetic shift of a signed product is the floor of the division
      pos = (unw * longint'(gain_cfg)) >>> 16;
      if (pos > 64'sd2147483647) pos = 64'sd2147483647;
      if (pos < -64'sd2147483648) pos = -64'sd2147483648;
      rep.axis_out        = r.axis;
      rep.turns           = turn_count[ax][TURNS_W-1:0];
      rep.unwrapped_count = unw[UNW_W-1:0];
      rep.scaled_position = pos[POS_W-1:0];
      return 1;
   endfunction

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (req_chan.valid) begin
            sent_count++;
            if (track_request(req_chan.payload, predicted_report))
               awaited_reports.push_back(predicted_report);
         end
         if (request_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
            req_chan.payload <= request_queue.pop_front();
            req_chan.valid   <= 1'b1;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Report monitor and receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (awaited_reports.size() == 0) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("%0t: report with none pending: axis %0d turns %0d unw %0d pos %0d",
                     $realtime, rsp_chan.payload.axis_out, rsp_chan.payload.turns,
                     rsp_chan.payload.unwrapped_count, rsp_chan.payload.scaled_position);
            end else begin
               want_report = awaited_reports.pop_front();
               checked_count++;
               if (rsp_chan.payload.axis_out !== want_report.axis_out ||
                   rsp_chan.payload.turns !== want_report.turns ||
                   rsp_chan.payload.unwrapped_count !== want_report.unwrapped_count ||
                   rsp_chan.payload.scaled_position !== want_report.scaled_position) begin
                  fault_count++;
                  if (fault_count <= 10) begin
                     $display("%0t: mismatch expected axis %0d turns %0d unw %0d pos %0d",
                        $realtime, want_report.axis_out, want_report.turns,
                        want_report.unwrapped_count, want_report.scaled_position);
                     $display("   got axis %0d turns %0d unw %0d pos %0d",
                        rsp_chan.payload.axis_out, rsp_chan.payload.turns,
                        rsp_chan.payload.unwrapped_count, rsp_chan.payload.scaled_position);
                  end
               end
            end
         end
         rsp_chan.ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
      end
   end

   task automatic push_req(input cmd_type c, input int ax, input int raw);
      req_type r;
      r.cmd       = c;
      r.axis      = ax[AXIS_W-1:0];
      r.raw_angle = raw[RAW_W-1:0];
      request_queue.push_back(r);
   endtask

   // Register write; the model copy changes at once since the block is idle
   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_CONNECTED_MASK) mask_cfg = val[MASK_W-1:0];
      else gain_cfg = val;
   endtask

   task automatic set_idling(input int tx_pct, input int rx_pct);
      @(posedge clock);
      tx_idle_pct  <= tx_pct;
      rx_stall_pct <= rx_pct;
   endtask

   // Wait until all requests are taken and all reports are back
   task automatic drain();
      while (request_queue.size() != 0 || req_chan.valid) @(posedge clock);
      while (awaited_reports.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Mostly smooth per-axis rotation so quadrant changes come in order
   task automatic queue_random(input int count);
      int               kind;
      int               ax;
      logic [RAW_W-1:0] step;
      for (int i = 0; i < count; i++) begin
         kind = $urandom_range(99);
         ax   = $urandom_range(0, AXES - 1);
         if (kind < 5) begin
            push_req($urandom_range(1) ? CMD_SAMPLE : CMD_CAPTURE,
               $urandom_range(AXES, 7), $urandom_range(0, 4095));
         end else if (kind < 11) begin
            push_req(CMD_CAPTURE, ax, $urandom_range(0, 4095));
         end else if (kind < 20) begin
            push_req(CMD_SAMPLE, ax, $urandom_range(0, 4095));
         end else begin
            step = RAW_W'($urandom_range(0, 600));
            walk_pos[ax] = walk_pos[ax] + step - 12'd300;
            push_req(CMD_SAMPLE, ax, walk_pos[ax]);
         end
      end
   endtask

   function automatic int raw_in_quad(input quad_type q);
      case (q)
         QUAD_1:  return $urandom_range(0, QUARTER);
         QUAD_2:  return $urandom_range(QUARTER + 1, 2 * QUARTER);
         QUAD_3:  return $urandom_range(2 * QUARTER + 1, 3 * QUARTER);
         default: return $urandom_range(3 * QUARTER + 1, 4095);
      endcase
   endfunction

   initial begin
      mask_cfg = MASK_RESET;
      gain_cfg = GAIN_RESET;
      for (int a = 0; a < AXES; a++) begin
         zero_offset[a] = '0;
         last_quad[a]   = QUAD_NONE;
         turn_count[a]  = 0;
      end
      foreach (walk_pos[a]) walk_pos[a] = $urandom_range(0, 4095);
      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: quadrant edges, wraps both ways, captures, absent axes
      write_csr(CSR_CONNECTED_MASK, 20'h3F);
      push_req(CMD_SAMPLE, 0, 0);
      push_req(CMD_SAMPLE, 0, 1024);
      push_req(CMD_SAMPLE, 0, 1025);
      push_req(CMD_SAMPLE, 0, 2048);
      push_req(CMD_SAMPLE, 0, 2049);
      push_req(CMD_SAMPLE, 0, 3072);
      push_req(CMD_SAMPLE, 0, 3073);
      push_req(CMD_SAMPLE, 0, 4095);
      push_req(CMD_SAMPLE, 0, 0);
      push_req(CMD_SAMPLE, 0, 4095);
      push_req(CMD_CAPTURE, 1, 4095);
      push_req(CMD_SAMPLE, 1, 4095);
      push_req(CMD_SAMPLE, 1, 4094);
      push_req(CMD_SAMPLE, 6, 100);
      push_req(CMD_CAPTURE, 7, 4095);
      push_req(CMD_SAMPLE, 7, 0);
      push_req(CMD_SAMPLE, 5, 4095);
      push_req(CMD_CAPTURE, 2, 2048);
      push_req(CMD_SAMPLE, 2, 0);
      drain();

      // Partial mask, zero gain, sparse sender
      write_csr(CSR_CONNECTED_MASK, 20'b010101);
      write_csr(CSR_POSITION_GAIN, '0);
      set_idling(88, 0);
      push_req(CMD_SAMPLE, 1, 500);
      push_req(CMD_CAPTURE, 3, 77);
      push_req(CMD_SAMPLE, 0, 2000);
      queue_random(300);
      drain();

      // Full mask, largest gain, slow receiver
      write_csr(CSR_CONNECTED_MASK, 20'h3F);
      write_csr(CSR_POSITION_GAIN, 20'hFFFFF);
      set_idling(0, 88);
      queue_random(300);
      drain();

      // Random settings, both sides idling
      write_csr(CSR_CONNECTED_MASK, CSR_DATA_W'($urandom_range(1, 63)));
      write_csr(CSR_POSITION_GAIN, 20'($urandom_range(0, 1048575)));
      set_idling(21, 21);
      queue_random(300);
      drain();

      // Nothing connected: every request is dropped
      write_csr(CSR_CONNECTED_MASK, '0);
      set_idling(0, 0);
      queue_random(12);
      drain();

      // Back pressure: receiver holds off long while requests keep coming
      write_csr(CSR_CONNECTED_MASK, 20'h3F);
      write_csr(CSR_POSITION_GAIN, GAIN_RESET);
      @(posedge clock);
      rx_hold <= 1'b1;
      fork
         begin
            repeat (400) @(posedge clock);
            rx_hold <= 1'b0;
         end
      join_none
      queue_random(300);
      drain();

      // Repeated full turns upward on axis 0 and downward on axis 1
      write_csr(CSR_POSITION_GAIN, 20'hFFFFF);
      push_req(CMD_CAPTURE, 0, 0);
      push_req(CMD_CAPTURE, 1, 0);
      for (int t = 0; t < SWEEP_TURNS; t++) begin
         push_req(CMD_SAMPLE, 0, raw_in_quad(QUAD_3));
         push_req(CMD_SAMPLE, 0, raw_in_quad(QUAD_4));
         push_req(CMD_SAMPLE, 0, raw_in_quad(QUAD_1));
      end
      for (int t = 0; t < SWEEP_TURNS; t++) begin
         push_req(CMD_SAMPLE, 1, raw_in_quad(QUAD_4));
         push_req(CMD_SAMPLE, 1, raw_in_quad(QUAD_2));
         push_req(CMD_SAMPLE, 1, raw_in_quad(QUAD_1));
      end
      drain();

      // Wrap-up with unit gain, both sides idling
      write_csr(CSR_POSITION_GAIN, 20'd1);
      set_idling(21, 21);
      queue_random(200);
      drain();

      $display("Sent %0d requests, checked %0d position reports over eight register setups,",
         sent_count, checked_count);
      $display("including quadrant edges, dropped axes, long back pressure and turn sweeps.");
      if (fault_count == 0 && awaited_reports.size() == 0) begin
         $display("multi_turn_angle_tracker test passed");
      end else begin
         $display("multi_turn_angle_tracker test failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/mat_pkg.sv
rtl/core/mat_chan_if.sv
rtl/core/mat_track.sv
rtl/core/multi_turn_angle_tracker.sv
test/testbench.sv
